// ===== src/sync_length_frame_deframer_core_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slfd_pkg.sv =====
// Shared types and constants of the sync/length deframer.
// No dependencies; imported by the front end and the top level.
package slfd_pkg;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  localparam logic CFG_SYNC_WORD    = 1'b0;
  localparam logic CFG_LENGTH_LIMIT = 1'b1;

  localparam logic [31:0] SYNC_WORD_RST    = 32'hAAEA_BDAC;
  localparam logic [15:0] LENGTH_LIMIT_RST = 16'd401;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [15:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [31:0] sync_word;
    logic [15:0] length_limit;
  } cfg_t;

endpackage

// ===== src/slfd_fifo.sv =====
// Small result queue between the framing front end and the output side.
// Depends on the assertion macros header only.
`include "sync_length_frame_deframer_core_macros.svh"

module slfd_fifo #(
  parameter int unsigned Width = 26,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `SLFD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(Depth), "queue count overflow")
  `SLFD_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty_o, "queue empty after push")
  `SLFD_ASSERT_NOW(a_ptr_sync, empty_o, wr_ptr_q == rd_ptr_q, "pointers differ while empty")

endmodule

// ===== src/slfd_front.sv =====
// Framing front end: sync hunt, length capture and payload counting.
// Depends on slfd_pkg and the assertion macros header.
`include "sync_length_frame_deframer_core_macros.svh"

module slfd_front import slfd_pkg::*; #(
  parameter int unsigned SyncBytes = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_valid_i,
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  localparam int unsigned WinW  = 8 * SyncBytes;
  localparam int unsigned FillW = $clog2(SyncBytes + 1);

  typedef enum logic [1:0] {
    PhHunt,
    PhLenLo,
    PhLenHi,
    PhPayload
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [WinW-1:0] window_q, window_d, window_shift, sync_ref;
  logic [FillW-1:0] fill_q, fill_d, fill_inc;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [15:0]     cur_len_q, cur_len_d, rem_q, rem_d, rem_dec, len_full;
  logic            match, reject, last;

  if (SyncBytes > 1) begin : g_shift_wide
    assign window_shift = {window_q[WinW-9:0], item_i.data_byte};
  end else begin : g_shift_byte
    assign window_shift = item_i.data_byte;
  end

  // Window bytes beyond the 32-bit register compare against zero.
  if (WinW > 32) begin : g_ref_wide
    assign sync_ref = {{(WinW - 32){1'b0}}, cfg_i.sync_word};
  end else begin : g_ref_narrow
    assign sync_ref = cfg_i.sync_word[WinW-1:0];
  end

  assign fill_inc = (fill_q < FillW'(SyncBytes)) ? fill_q + 1'b1 : fill_q;
  assign match    = (fill_inc == FillW'(SyncBytes)) && (window_shift == sync_ref);
  assign len_full = {item_i.data_byte, len_lo_q};
  assign reject   = (len_full == '0) || (len_full >= cfg_i.length_limit);
  assign rem_dec  = (rem_q == '0) ? '0 : rem_q - 16'd1;
  assign last     = (rem_dec == '0);

  always_comb begin
    phase_d     = phase_q;
    window_d    = window_q;
    fill_d      = fill_q;
    len_lo_d    = len_lo_q;
    cur_len_d   = cur_len_q;
    rem_d       = rem_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (item_valid_i) begin
      if (item_i.op == OP_RESTART) begin
        phase_d   = PhHunt;
        window_d  = '0;
        fill_d    = '0;
        len_lo_d  = '0;
        cur_len_d = '0;
        rem_d     = '0;
      end else begin
        unique case (phase_q)
          PhHunt: begin
            if (match) begin
              window_d = '0;
              fill_d   = '0;
              phase_d  = PhLenLo;
            end else begin
              window_d = window_shift;
              fill_d   = fill_inc;
            end
          end
          PhLenLo: begin
            len_lo_d = item_i.data_byte;
            phase_d  = PhLenHi;
          end
          PhLenHi: begin
            cur_len_d = len_full;
            if (reject) begin
              res_valid_o        = 1'b1;
              res_o.kind         = KIND_REJECT;
              res_o.frame_length = len_full;
              phase_d            = PhHunt;
              window_d           = '0;
              fill_d             = '0;
              len_lo_d           = '0;
              cur_len_d          = '0;
              rem_d              = '0;
            end else begin
              rem_d   = len_full;
              phase_d = PhPayload;
            end
          end
          PhPayload: begin
            res_valid_o        = 1'b1;
            res_o.kind         = KIND_PAYLOAD;
            res_o.payload_byte = item_i.data_byte;
            res_o.frame_last   = last;
            res_o.frame_length = cur_len_q;
            rem_d              = rem_dec;
            if (last) begin
              phase_d   = PhHunt;
              window_d  = '0;
              fill_d    = '0;
              len_lo_d  = '0;
              cur_len_d = '0;
            end
          end
          default: phase_d = PhHunt;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      window_q  <= '0;
      fill_q    <= '0;
      len_lo_q  <= '0;
      cur_len_q <= '0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      window_q  <= window_d;
      fill_q    <= fill_d;
      len_lo_q  <= len_lo_d;
      cur_len_q <= cur_len_d;
      rem_q     <= rem_d;
    end
  end

  `SLFD_ASSERT_NOW(a_reject_len, res_valid_o && res_o.kind == KIND_REJECT,
      res_o.frame_length == '0 || res_o.frame_length >= cfg_i.length_limit,
      "rejected a legal length")
  `SLFD_ASSERT_NEXT(a_last_hunts, res_valid_o && res_o.frame_last, phase_q == PhHunt,
      "no return to hunt after last byte")
  `SLFD_ASSERT_NOW(a_payload_rem, phase_q == PhPayload, rem_q != '0,
      "payload phase with nothing remaining")

endmodule

// ===== src/sync_length_frame_deframer_core.sv =====
// Top level of the sync-word / length-prefixed deframer.
// Depends on slfd_pkg, slfd_front and slfd_fifo.
//
// Usage:
//   Input channel: drive item_i and raise push; a beat is taken when full is low.
//     op = OP_BYTE carries one stream byte, op = OP_RESTART drops all framing state.
//   Result channel: while empty is low, result_o holds the oldest result; raise
//     pop to take the beat. Results are payload bytes (frame_last on the final
//     one) or a rejection carrying the offending length.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 = sync word,
//     1 = length limit) and cfg_data_i. Always ready; write only while idle.
//   Timing: a result is visible in the cycle after its input beat is taken.
//   Throughput: one byte per cycle while full is low; the framing state machine
//     steps on every taken beat and the result queue absorbs short receiver stalls.
//   Stall: when the receiver holds pop low the queue fills (QueueDepth beats)
//     and full rises, which holds off further input until a beat is popped.
//   Reset: framing returns to sync hunt, the queue empties, and the registers
//     take their defaults (sync word 0xAAEABDAC, length limit 401).
module sync_length_frame_deframer_core import slfd_pkg::*; #(
  parameter int unsigned SyncBytes  = 4,
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  // result stream
  output logic        empty,
  input  logic        pop,
  output result_t     result_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    item_take;
  logic    res_valid;
  result_t res;

  // Registers can always be written; there is nothing to wait on.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SYNC_WORD:    cfg_d.sync_word    = cfg_data_i;
        CFG_LENGTH_LIMIT: cfg_d.length_limit = cfg_data_i[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word    <= SYNC_WORD_RST;
      cfg_q.length_limit <= LENGTH_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take a beat only when the queue has room for a possible result.
  assign item_take = push && !full;

  slfd_front #(
    .SyncBytes(SyncBytes)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_take),
    .item_i      (item_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Queue decouples the framing logic from the receiver.
  slfd_fifo #(
    .Width($bits(result_t)),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .wdata_i(res),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(result_o),
    .empty_o(empty)
  );

endmodule
